// ===== rtl/core/sgf_pkg.sv =====
// Shared constants, types and helpers of the Savitzky-Golay smoother.
// No dependencies; every other file of the block refers to it by scoped names.
package sgf_pkg;

   localparam int SEMI_WIDTH = 3;
   localparam int DLY_LEN    = 2 * SEMI_WIDTH;
   localparam int TAPS       = 2 * SEMI_WIDTH + 1;
   localparam int NUM_COEFF  = 7;
   localparam int CNT_W      = $clog2(SEMI_WIDTH + 1);

   localparam int SAMPLE_W   = 16;
   localparam int COEFF_W    = 18;
   localparam int SCALE_W    = 24;
   localparam int VALUE_W    = 24;
   localparam int PROD_W     = SAMPLE_W + COEFF_W;
   localparam int ACC_W      = PROD_W + $clog2(TAPS);
   localparam int ACC_LO_W   = 20;
   localparam int ACC_HI_W   = ACC_W - ACC_LO_W;
   localparam int PLO_W      = ACC_LO_W + 1 + SCALE_W;
   localparam int PHI_W      = ACC_HI_W + SCALE_W;
   localparam int FULL_W     = ACC_W + SCALE_W + 1;
   localparam int ROUND_SH   = 32;
   localparam int RND_W      = FULL_W - ROUND_SH;
   localparam int VALUE_MAX  = 2 ** (VALUE_W - 1) - 1;
   localparam int VALUE_MIN  = -(2 ** (VALUE_W - 1));

   localparam int REG_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int REG_SCALE   = 7;
   localparam int COEFF0_RESET = 65536;
   localparam int SCALE_RESET  = 65536;

   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEFF_W-1:0]  coeff_type;
   typedef logic signed [SCALE_W-1:0]  scale_type;

   // fill: shift only; short: stream too short, error word; run: filter step
   typedef enum logic [1:0] {
      OP_FILL  = 2'd0,
      OP_SHORT = 2'd1,
      OP_RUN   = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      sample_type  sample;
      logic        last;
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SUM   = 4'b0010,
      ST_SCALE = 4'b0100,
      ST_OUT   = 4'b1000
   } back_state_type;

   // Coefficient applied to delay tap k (k = 0 is the newest older sample),
   // wrap-around order: first half uses N+1.., second half uses 1..
   function automatic int coef_sel(input int k);
      if (k < SEMI_WIDTH) return SEMI_WIDTH + 1 + k;
      else                return k - SEMI_WIDTH + 1;
   endfunction

endpackage

// ===== rtl/core/sgf_req_if.sv =====
// Input channel of the smoother: valid/ready plus one sample word and a last flag.
// Depends on sgf_pkg for the sample type.
interface sgf_req_if;
   logic                valid;
   logic                ready;
   sgf_pkg::sample_type sample;
   logic                is_last;

   modport source (output valid, sample, is_last, input ready);
   modport sink   (input valid, sample, is_last, output ready);
endinterface

// ===== rtl/core/sgf_rsp_if.sv =====
// Result channel of the smoother: valid/ready plus value, status and last.
// Depends on sgf_pkg for the value width.
interface sgf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [sgf_pkg::VALUE_W-1:0] value;
   logic                               status;
   logic                               last;

   modport source (output valid, value, status, last, input ready);
   modport sink   (input valid, value, status, last, output ready);
endinterface

// ===== rtl/core/sgf_csr_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on sgf_pkg for field widths.
interface sgf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sgf_pkg::REG_IDX_W-1:0]     index;
   logic [sgf_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sgf_cfg.sv =====
// Coefficient and scale registers, written through the configuration channel.
// Depends on sgf_pkg and sgf_csr_if.
module sgf_cfg (
   input  logic                 clock,
   input  logic                 reset,
   sgf_csr_if.sink              csr,
   output sgf_pkg::coeff_type   coeff [sgf_pkg::NUM_COEFF],
   output sgf_pkg::scale_type   scale
);

   sgf_pkg::coeff_type coeff_ff [sgf_pkg::NUM_COEFF];
   sgf_pkg::coeff_type coeff_in [sgf_pkg::NUM_COEFF];
   sgf_pkg::scale_type scale_ff, scale_in;
   logic               wr_en;

   assign csr.ready = 1'b1;
   assign wr_en     = csr.valid;

   always_comb begin
      coeff_in = coeff_ff;
      scale_in = scale_ff;
      if (wr_en) begin
         for (int k = 0; k < sgf_pkg::NUM_COEFF; k++) begin
            if (csr.index == sgf_pkg::REG_IDX_W'(k)) begin
               coeff_in[k] = csr.data[sgf_pkg::COEFF_W-1:0];
            end
         end
         if (csr.index == sgf_pkg::REG_IDX_W'(sgf_pkg::REG_SCALE)) begin
            scale_in = csr.data[sgf_pkg::SCALE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < sgf_pkg::NUM_COEFF; k++) begin
            coeff_ff[k] <= '0;
         end
         coeff_ff[0] <= sgf_pkg::COEFF_W'(sgf_pkg::COEFF0_RESET);
         scale_ff    <= sgf_pkg::SCALE_W'(sgf_pkg::SCALE_RESET);
      end else begin
         coeff_ff <= coeff_in;
         scale_ff <= scale_in;
      end
   end

   assign coeff = coeff_ff;
   assign scale = scale_ff;

endmodule

// ===== rtl/core/sgf_front.sv =====
// Front end: accepts sample words and classifies them by the stream fill state.
// Depends on sgf_pkg and sgf_req_if; feeds sgf_queue.
module sgf_front (
   input  logic            clock,
   input  logic            reset,
   sgf_req_if.sink         req,
   output logic            push_valid,
   output sgf_pkg::op_type push_op,
   input  logic            push_ready
);

   logic [sgf_pkg::CNT_W-1:0] fill_ff, fill_in;
   logic [sgf_pkg::CNT_W:0]   fill_next;
   logic                      accept;

   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign accept     = req.valid && push_ready;
   assign fill_next  = {1'b0, fill_ff} + 1'b1;

   always_comb begin
      push_op.sample = req.sample;
      push_op.last   = req.is_last;
      fill_in        = fill_ff;
      if (fill_ff < sgf_pkg::CNT_W'(sgf_pkg::SEMI_WIDTH)) begin
         if (req.is_last &&
             fill_next < (sgf_pkg::CNT_W + 1)'(sgf_pkg::SEMI_WIDTH)) begin
            push_op.kind = sgf_pkg::OP_SHORT;
         end else begin
            push_op.kind = sgf_pkg::OP_FILL;
         end
         if (accept) begin
            fill_in = req.is_last ? '0 : fill_next[sgf_pkg::CNT_W-1:0];
         end
      end else begin
         push_op.kind = sgf_pkg::OP_RUN;
         if (accept && req.is_last) begin
            fill_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== rtl/core/sgf_queue.sv =====
// Short register FIFO of classified operations between front and back end.
// Depends on sgf_pkg.
module sgf_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   input  sgf_pkg::op_type push_op,
   output logic            push_ready,
   output logic            pop_valid,
   output sgf_pkg::op_type pop_op,
   input  logic            pop
);

   sgf_pkg::op_type            entry_ff [sgf_pkg::QDEPTH];
   logic [sgf_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sgf_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sgf_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign push_ready = count_ff != sgf_pkg::QCNT_W'(sgf_pkg::QDEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sgf_pkg::QPTR_W'(sgf_pkg::QDEPTH - 1)) ? '0
                                                                         : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sgf_pkg::QPTR_W'(sgf_pkg::QDEPTH - 1)) ? '0
                                                                         : rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/core/sgf_back.sv =====
// Back end: delay line, tap products, accumulate, scale, round, saturate,
// zero flush and result register. Depends on sgf_pkg and sgf_rsp_if.
module sgf_back (
   input  logic               clock,
   input  logic               reset,
   input  sgf_pkg::coeff_type coeff [sgf_pkg::NUM_COEFF],
   input  sgf_pkg::scale_type scale,
   input  logic               pop_valid,
   input  sgf_pkg::op_type    pop_op,
   output logic               pop,
   sgf_rsp_if.source          rsp
);

   typedef logic signed [sgf_pkg::PROD_W-1:0] prod_type;

   sgf_pkg::back_state_type    state_ff, state_in;
   sgf_pkg::sample_type        dly_ff  [sgf_pkg::DLY_LEN];
   sgf_pkg::sample_type        dly_in  [sgf_pkg::DLY_LEN];
   prod_type                   prod_ff [sgf_pkg::TAPS];
   prod_type                   prod_in [sgf_pkg::TAPS];
   logic signed [sgf_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [sgf_pkg::PLO_W-1:0]  plo_ff, plo_in;
   logic signed [sgf_pkg::PHI_W-1:0]  phi_ff, phi_in;
   logic                       flush_ff, flush_in;
   logic [sgf_pkg::CNT_W-1:0]  fcnt_ff, fcnt_in;
   logic                       res_last_ff, res_last_in;
   logic                       vld_ff, vld_in;
   logic signed [sgf_pkg::VALUE_W-1:0] val_ff, val_in;
   logic                       status_ff, status_in;
   logic                       last_ff, last_in;

   logic                       out_free, launch, do_shift, do_clear;
   sgf_pkg::sample_type        x_sel;
   logic signed [sgf_pkg::FULL_W-1:0] full;
   logic signed [sgf_pkg::RND_W-1:0]  rnd;
   logic signed [sgf_pkg::VALUE_W-1:0] sat;

   assign out_free = !vld_ff || rsp.ready;

   // newest sample against coeff 0, delay taps in wrap-around order
   always_comb begin
      prod_in[0] = sgf_pkg::PROD_W'(x_sel) * sgf_pkg::PROD_W'(coeff[0]);
      for (int k = 0; k < sgf_pkg::DLY_LEN; k++) begin
         prod_in[k+1] = sgf_pkg::PROD_W'(dly_ff[k]) *
                        sgf_pkg::PROD_W'(coeff[sgf_pkg::coef_sel(k)]);
      end
   end

   always_comb begin
      acc_in = '0;
      for (int k = 0; k < sgf_pkg::TAPS; k++) begin
         acc_in = acc_in + sgf_pkg::ACC_W'(prod_ff[k]);
      end
   end

   // acc * scale split into low (unsigned) and high (signed) partial products
   assign plo_in = sgf_pkg::PLO_W'($signed({1'b0, acc_ff[sgf_pkg::ACC_LO_W-1:0]})) *
                   sgf_pkg::PLO_W'(scale);
   assign phi_in = sgf_pkg::PHI_W'($signed(acc_ff[sgf_pkg::ACC_W-1:sgf_pkg::ACC_LO_W])) *
                   sgf_pkg::PHI_W'(scale);

   // round half up, then saturate
   assign full = (sgf_pkg::FULL_W'(phi_ff) <<< sgf_pkg::ACC_LO_W) +
                 sgf_pkg::FULL_W'(plo_ff) +
                 (sgf_pkg::FULL_W'(1) <<< (sgf_pkg::ROUND_SH - 1));
   assign rnd  = full[sgf_pkg::FULL_W-1:sgf_pkg::ROUND_SH];

   always_comb begin
      priority if (rnd > $signed(sgf_pkg::RND_W'(sgf_pkg::VALUE_MAX))) begin
         sat = sgf_pkg::VALUE_W'(sgf_pkg::VALUE_MAX);
      end else if (rnd < $signed(sgf_pkg::RND_W'(sgf_pkg::VALUE_MIN))) begin
         sat = sgf_pkg::VALUE_W'(sgf_pkg::VALUE_MIN);
      end else begin
         sat = rnd[sgf_pkg::VALUE_W-1:0];
      end
   end

   always_comb begin
      state_in    = state_ff;
      flush_in    = flush_ff;
      fcnt_in     = fcnt_ff;
      res_last_in = res_last_ff;
      vld_in      = vld_ff && !rsp.ready;
      val_in      = val_ff;
      status_in   = status_ff;
      last_in     = last_ff;
      pop         = 1'b0;
      launch      = 1'b0;
      do_shift    = 1'b0;
      do_clear    = 1'b0;
      x_sel       = pop_op.sample;

      unique case (state_ff)
         sgf_pkg::ST_IDLE: begin
            if (flush_ff) begin
               x_sel       = '0;
               launch      = 1'b1;
               do_shift    = 1'b1;
               fcnt_in     = fcnt_ff + 1'b1;
               res_last_in = fcnt_ff == sgf_pkg::CNT_W'(sgf_pkg::SEMI_WIDTH - 1);
               if (res_last_in) begin
                  // products are captured this cycle, state may clear now
                  flush_in = 1'b0;
                  do_clear = 1'b1;
               end
            end else if (pop_valid) begin
               unique case (pop_op.kind)
                  sgf_pkg::OP_FILL: begin
                     pop      = 1'b1;
                     do_shift = 1'b1;
                     if (pop_op.last) begin
                        flush_in = 1'b1;
                        fcnt_in  = '0;
                     end
                  end
                  sgf_pkg::OP_RUN: begin
                     pop         = 1'b1;
                     launch      = 1'b1;
                     do_shift    = 1'b1;
                     res_last_in = 1'b0;
                     if (pop_op.last) begin
                        flush_in = 1'b1;
                        fcnt_in  = '0;
                     end
                  end
                  sgf_pkg::OP_SHORT: begin
                     if (out_free) begin
                        pop       = 1'b1;
                        do_clear  = 1'b1;
                        vld_in    = 1'b1;
                        val_in    = '0;
                        status_in = 1'b1;
                        last_in   = 1'b1;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
            if (launch) begin
               state_in = sgf_pkg::ST_SUM;
            end
         end
         sgf_pkg::ST_SUM: begin
            state_in = sgf_pkg::ST_SCALE;
         end
         sgf_pkg::ST_SCALE: begin
            state_in = sgf_pkg::ST_OUT;
         end
         sgf_pkg::ST_OUT: begin
            if (out_free) begin
               vld_in    = 1'b1;
               val_in    = sat;
               status_in = 1'b0;
               last_in   = res_last_ff;
               state_in  = sgf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sgf_pkg::ST_IDLE;
         end
      endcase

      dly_in = dly_ff;
      if (do_shift) begin
         dly_in[0] = x_sel;
         for (int k = 1; k < sgf_pkg::DLY_LEN; k++) begin
            dly_in[k] = dly_ff[k-1];
         end
      end
      if (do_clear) begin
         for (int k = 0; k < sgf_pkg::DLY_LEN; k++) begin
            dly_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sgf_pkg::ST_IDLE;
         flush_ff    <= 1'b0;
         fcnt_ff     <= '0;
         res_last_ff <= 1'b0;
         vld_ff      <= 1'b0;
         for (int k = 0; k < sgf_pkg::DLY_LEN; k++) begin
            dly_ff[k] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         flush_ff    <= flush_in;
         fcnt_ff     <= fcnt_in;
         res_last_ff <= res_last_in;
         vld_ff      <= vld_in;
         dly_ff      <= dly_in;
      end
   end

   always_ff @(posedge clock) begin
      if (launch) begin
         prod_ff <= prod_in;
      end
      if (state_ff == sgf_pkg::ST_SUM) begin
         acc_ff <= acc_in;
      end
      if (state_ff == sgf_pkg::ST_SCALE) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      val_ff    <= val_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp.valid  = vld_ff;
   assign rsp.value  = val_ff;
   assign rsp.status = status_ff;
   assign rsp.last   = last_ff;

endmodule

// ===== rtl/core/savitzky_golay_fir_smoother_core.sv =====
// Savitzky-Golay FIR smoother, N = 3. An accepted sample passes the queue, then the
// product, sum, scale and round/saturate registers before its filtered word is valid.
// Fill samples go 1 per cycle while the back end is idle and not flushing; each result
// holds the shared back end from launch to output; a last sample adds N flush results.
// Reset (synchronous, active high) empties the queue, zeroes the delay line and
// fill count, drops any pending word and restores coeff_0 = 1.0, scale = 1.0.
module savitzky_golay_fir_smoother_core (
   input logic     clock,
   input logic     reset,
   sgf_req_if.sink   req_chan,
   sgf_rsp_if.source rsp_chan,
   sgf_csr_if.sink   csr_chan
);

   sgf_pkg::coeff_type coeff [sgf_pkg::NUM_COEFF];
   sgf_pkg::scale_type scale;
   logic               push_valid, push_ready;
   sgf_pkg::op_type    push_op;
   logic               pop_valid, pop;
   sgf_pkg::op_type    pop_op;

   sgf_cfg u_cfg (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .coeff (coeff),
      .scale (scale)
   );

   sgf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready)
   );

   sgf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_op     (pop_op),
      .pop        (pop)
   );

   sgf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .coeff     (coeff),
      .scale     (scale),
      .pop_valid (pop_valid),
      .pop_op    (pop_op),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

endmodule

// ===== rtl/core/sgf_checker.sv =====
// Port-level checks on the smoother result channel, and the bind that
// attaches them to savitzky_golay_fir_smoother_core. Depends on sgf_pkg.
module sgf_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [sgf_pkg::VALUE_W-1:0] rsp_value,
   input logic                               rsp_status,
   input logic                               rsp_last
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) &&
                                  $stable(rsp_status) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // short-stream error word is zero and ends the stream
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last && rsp_value == '0)
      else $error("error word malformed");

   // nothing pending right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind savitzky_golay_fir_smoother_core sgf_checker u_sgf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_value  (rsp_chan.value),
   .rsp_status (rsp_chan.status),
   .rsp_last   (rsp_chan.last)
);
